FILE: rtl/core/joint_bilateral_residual_filter_top_defines.svh
// ----------------------------------------------------------------------------
// Joint bilateral residual filter: assertion macros
// Shared property wrappers for the port checker.
// ----------------------------------------------------------------------------
`ifndef JOINT_BILATERAL_RESIDUAL_FILTER_TOP_DEFINES_SVH
`define JOINT_BILATERAL_RESIDUAL_FILTER_TOP_DEFINES_SVH

// checked on every edge outside reset
`define JBRF_CHECK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every edge, reset included
`define JBRF_CHECK_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/core/jbrf_pkg.sv
// ----------------------------------------------------------------------------
// Joint bilateral residual filter package
// Shared constants, pixel record type, register indexes and helper functions.
// ----------------------------------------------------------------------------
`default_nettype none

package jbrf_pkg;

  localparam int MAX_ROWS_DEF    = 64;
  localparam int MAX_COLS_DEF    = 64;
  localparam int MAX_RADIUS_DEF  = 15;
  localparam int EXP_ENTRIES_DEF = 2000;

  localparam int CFG_W     = 24;
  localparam int CFG_IDX_W = 3;
  localparam int WEIGHT_W  = 17;
  localparam int MUL_A_W   = 18;
  localparam int MUL_B_W   = 24;
  localparam int MUL_P_W   = MUL_A_W + MUL_B_W;

  localparam logic [CFG_IDX_W-1:0] CFG_ROWS   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LOC    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FLOW   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_COLOUR = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN   = 3'd6;

  // one frame memory word
  typedef struct packed {
    logic [15:0] res;
    logic [15:0] fu;
    logic [15:0] fv;
    logic [15:0] bu;
    logic [15:0] bv;
    logic [7:0]  cr;
    logic [7:0]  cg;
    logic [7:0]  cb;
  } pix_t;

  localparam int MEM_W = $bits(pix_t);

  function automatic logic [15:0] absdiff_s16(input logic [15:0] a, input logic [15:0] b);
    logic signed [16:0] d;
    d = $signed({a[15], a}) - $signed({b[15], b});
    return d[16] ? 16'(-d) : d[15:0];
  endfunction

  function automatic logic [7:0] absdiff_u8(input logic [7:0] a, input logic [7:0] b);
    return (a >= b) ? (a - b) : (b - a);
  endfunction

  function automatic logic [6:0] absdiff_u7(input logic [6:0] a, input logic [6:0] b);
    return (a >= b) ? (a - b) : (b - a);
  endfunction

  // series divisor, elaboration only
  function automatic logic [63:0] div_small(input logic [63:0] x, input int k);
    case (k)
      2:  return x / 2;
      3:  return x / 3;
      4:  return x / 4;
      5:  return x / 5;
      6:  return x / 6;
      7:  return x / 7;
      8:  return x / 8;
      9:  return x / 9;
      10: return x / 10;
      11: return x / 11;
      12: return x / 12;
      default: return x;
    endcase
  endfunction

  // exp(-16 t) in Q0.30 via 13-term series and four squarings, out Q1.16
  function automatic logic [WEIGHT_W-1:0] exp_series(input logic [63:0] t);
    logic [63:0] s;
    logic [63:0] term;
    s    = 64'd1 << 30;
    term = 64'd1 << 30;
    for (int k = 1; k <= 12; k++) begin
      term = div_small((term * t) >> 30, k);
      if (k[0]) s = s - term;
      else      s = s + term;
    end
    for (int n = 0; n < 4; n++) begin
      s = (s * s + (64'd1 << 29)) >> 30;
    end
    return WEIGHT_W'((s + 64'd8192) >> 14);
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/jbrf_frame_mem.sv
// ----------------------------------------------------------------------------
// Frame memory
// One write port, one registered read port; holds residual, flows, colour.
// ----------------------------------------------------------------------------
`default_nettype none

module jbrf_frame_mem import jbrf_pkg::*; #(
  parameter  int DEPTH = MAX_ROWS_DEF * MAX_COLS_DEF,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [MEM_W-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [MEM_W-1:0] rd_data
);

  logic [MEM_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

FILE: rtl/core/jbrf_exp_rom.sv
// ----------------------------------------------------------------------------
// Exponential weight ROM
// exp(-5 i / entries) in Q1.16, built at elaboration, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module jbrf_exp_rom import jbrf_pkg::*; #(
  parameter  int EXP_ENTRIES = EXP_ENTRIES_DEF,
  localparam int IW          = $clog2(EXP_ENTRIES)
) (
  input  logic                clk,
  input  logic [IW-1:0]       addr,
  output logic [WEIGHT_W-1:0] weight
);

  typedef logic [WEIGHT_W-1:0] rom_t [EXP_ENTRIES];

  function automatic rom_t build_rom();
    rom_t tab;
    for (int i = 0; i < EXP_ENTRIES; i++) begin
      tab[i] = exp_series(((64'(i) * 64'd5) << 26) / EXP_ENTRIES);
    end
    return tab;
  endfunction

  localparam rom_t ROM = build_rom();

  always_ff @(posedge clk) begin
    weight <= ROM[addr];
  end

endmodule

`default_nettype wire

FILE: rtl/core/jbrf_mul.sv
// ----------------------------------------------------------------------------
// Shared multiplier
// Unsigned 18 x 24 product, registered; one result per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module jbrf_mul import jbrf_pkg::*; (
  input  logic               clk,
  input  logic [MUL_A_W-1:0] a,
  input  logic [MUL_B_W-1:0] b,
  output logic [MUL_P_W-1:0] p
);

  always_ff @(posedge clk) begin
    p <= MUL_P_W'(a) * MUL_P_W'(b);
  end

endmodule

`default_nettype wire

FILE: rtl/core/jbrf_divider.sv
// ----------------------------------------------------------------------------
// Restoring divider
// Unsigned, one quotient bit per cycle, NUM_W quotient bits in all.
// ----------------------------------------------------------------------------
`default_nettype none

module jbrf_divider #(
  parameter int NUM_W = 42,
  parameter int DEN_W = 27
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] dividend,
  input  logic [DEN_W-1:0] divisor,
  output logic             done,
  output logic [NUM_W-1:0] quotient
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [DEN_W:0]   rem;
  logic [NUM_W-1:0] quo;
  logic [DEN_W-1:0] dvs;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [DEN_W:0]   shifted;
  logic             ge;
  logic [DEN_W:0]   rem_next;

  always_comb begin
    shifted  = {rem[DEN_W-1:0], quo[NUM_W-1]};
    ge       = (shifted >= {1'b0, dvs});
    rem_next = ge ? (shifted - {1'b0, dvs}) : shifted;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem  <= '0;
        quo  <= dividend;
        dvs  <= divisor;
        cnt  <= CNT_W'(NUM_W);
        busy <= 1'b1;
      end else if (busy) begin
        rem <= rem_next;
        quo <= {quo[NUM_W-2:0], ge};
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = quo;

endmodule

`default_nettype wire

FILE: rtl/core/joint_bilateral_residual_filter_top.sv
// Flow: a write item is stored on accept. A filter item outside the frame gives its result
//   without a window walk; inside, it walks N window pixels (up to 961) and then divides.
// Throughput: one item at a time; each window pixel passes in turn through the memory read,
//   the single shared 18x24 multiplier (17 sequencer steps) and the exp ROM read.
// Reset: synchronous, active high; clears the sequencer and output valid and loads the
//   register defaults. Frame memory is not cleared. NUM_W quotient bits, 42 by default.
// ----------------------------------------------------------------------------
// Joint bilateral residual filter, top level
// Write items store one pixel record; filter items walk a clipped window,
// weight each pixel through an exp ROM and divide sum(res*w) by sum(w)+1.
// ----------------------------------------------------------------------------
`default_nettype none

module joint_bilateral_residual_filter_top import jbrf_pkg::*; #(
  parameter int MAX_ROWS    = MAX_ROWS_DEF,
  parameter int MAX_COLS    = MAX_COLS_DEF,
  parameter int MAX_RADIUS  = MAX_RADIUS_DEF,
  parameter int EXP_ENTRIES = EXP_ENTRIES_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  // input item channel
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 func,
  input  logic [5:0]           pixel_row,
  input  logic [5:0]           pixel_col,
  input  logic signed [15:0]   residual_value,
  input  logic signed [15:0]   forward_u,
  input  logic signed [15:0]   forward_v,
  input  logic signed [15:0]   backward_u,
  input  logic signed [15:0]   backward_v,
  input  logic [7:0]           red,
  input  logic [7:0]           green,
  input  logic [7:0]           blue,
  // result item channel
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [5:0]           out_row,
  output logic [5:0]           out_col,
  output logic signed [15:0]   filtered_value,
  // configuration write port
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int DEPTH      = MAX_ROWS * MAX_COLS;
  localparam int AW         = $clog2(DEPTH);
  localparam int IW         = $clog2(EXP_ENTRIES);
  localparam int RAD_CLAMP  = (MAX_RADIUS < 15) ? MAX_RADIUS : 15;
  localparam int RW         = $clog2(RAD_CLAMP + 1);
  localparam int LW         = 2 * RW + 1;
  localparam int WIN_MAX    = (2 * RAD_CLAMP + 1) * (2 * RAD_CLAMP + 1);
  localparam int CNTW       = $clog2(WIN_MAX + 1);
  localparam int DEN_W      = 17 + CNTW;
  localparam int NUM_W      = 32 + CNTW;
  localparam int ROWS_CLAMP = (MAX_ROWS > 127) ? 127 : MAX_ROWS;
  localparam int COLS_CLAMP = (MAX_COLS > 127) ? 127 : MAX_COLS;

  typedef enum logic [3:0] {
    S_IDLE, S_CEN, S_RD, S_CAP, S_MUL, S_ROM, S_WGT, S_ACC, S_DSTART, S_DWAIT, S_DONE
  } state_t;

  // multiplier sequence, at most one operation issued per step
  typedef enum logic [4:0] {
    OP_FU, OP_FV, OP_BU, OP_BV, OP_CR, OP_CG, OP_CB, OP_LOC, OP_COL, OP_FLO, OP_FHI,
    OP_DSUM, OP_GLO, OP_GMID, OP_GHI, OP_GSUM, OP_IDX
  } op_t;

  // configuration registers
  logic [6:0]  rows_in_use;
  logic [6:0]  cols_in_use;
  logic [3:0]  window_radius;
  logic [23:0] location_scale;
  logic [23:0] flow_scale;
  logic [23:0] colour_scale;
  logic [23:0] index_gain;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_in_use    <= 7'd64;
      cols_in_use    <= 7'd64;
      window_radius  <= 4'd15;
      location_scale <= 24'd65536;
      flow_scale     <= 24'd65536;
      colour_scale   <= 24'd65536;
      index_gain     <= 24'd102400;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_ROWS:   rows_in_use    <= cfg_data[6:0];
        CFG_COLS:   cols_in_use    <= cfg_data[6:0];
        CFG_RADIUS: window_radius  <= cfg_data[3:0];
        CFG_LOC:    location_scale <= cfg_data;
        CFG_FLOW:   flow_scale     <= cfg_data;
        CFG_COLOUR: colour_scale   <= cfg_data;
        CFG_GAIN:   index_gain     <= cfg_data;
        default: ;
      endcase
    end
  end

  state_t st;
  op_t    step;

  logic [5:0]  row_q, col_q;
  logic [6:0]  r, c, y0, y1, x0, x1;
  pix_t        cen;
  logic [15:0] mag_fu, mag_fv, mag_bu, mag_bv, res_mag;
  logic [7:0]  mag_r, mag_g, mag_b;
  logic        res_neg;
  logic [LW-1:0] loc;
  logic [33:0] fsum;
  logic [17:0] csum;
  logic [59:0] dist_acc;
  logic [63:0] prod_i;
  logic [IW-1:0] rom_addr;
  logic signed [NUM_W:0] num;
  logic [DEN_W-1:0] den;
  logic [15:0] res_val;

  // accept side
  logic       in_acc;
  logic [6:0] rows_eff, cols_eff, row7, col7;
  logic [3:0] rad_eff;
  logic       in_frame, wr_ok;
  logic [6:0] y0_c, y1_c, x0_c, x1_c;
  logic [AW-1:0] in_addr, win_addr, rd_addr;
  pix_t       wr_pix, rd_pix;
  logic [MEM_W-1:0] rd_word;

  assign in_stall = (st != S_IDLE);
  assign in_acc   = in_valid && !in_stall;

  always_comb begin
    rows_eff = (rows_in_use == 7'd0) ? 7'd1 :
               ((32'(rows_in_use) > MAX_ROWS) ? 7'(ROWS_CLAMP) : rows_in_use);
    cols_eff = (cols_in_use == 7'd0) ? 7'd1 :
               ((32'(cols_in_use) > MAX_COLS) ? 7'(COLS_CLAMP) : cols_in_use);
    rad_eff  = (32'(window_radius) > MAX_RADIUS) ? 4'(RAD_CLAMP) : window_radius;
    row7     = {1'b0, pixel_row};
    col7     = {1'b0, pixel_col};
    in_frame = (row7 < rows_eff) && (col7 < cols_eff);
    wr_ok    = (32'(pixel_row) < MAX_ROWS) && (32'(pixel_col) < MAX_COLS);
    // window clipped to the frame
    y0_c = (row7 > 7'(rad_eff)) ? (row7 - 7'(rad_eff)) : 7'd0;
    y1_c = ((row7 + 7'(rad_eff)) > (rows_eff - 7'd1)) ? (rows_eff - 7'd1)
                                                      : (row7 + 7'(rad_eff));
    x0_c = (col7 > 7'(rad_eff)) ? (col7 - 7'(rad_eff)) : 7'd0;
    x1_c = ((col7 + 7'(rad_eff)) > (cols_eff - 7'd1)) ? (cols_eff - 7'd1)
                                                      : (col7 + 7'(rad_eff));
    in_addr  = AW'(32'(pixel_row) * MAX_COLS + 32'(pixel_col));
    win_addr = AW'(32'(r) * MAX_COLS + 32'(c));
    rd_addr  = (st == S_IDLE) ? in_addr : win_addr;
    wr_pix   = '{res: residual_value, fu: forward_u, fv: forward_v, bu: backward_u,
                 bv: backward_v, cr: red, cg: green, cb: blue};
  end

  assign rd_pix = pix_t'(rd_word);

  jbrf_frame_mem #(.DEPTH(DEPTH)) u_mem (
    .clk     (clk),
    .wr_en   (in_acc && !func && wr_ok),
    .wr_addr (in_addr),
    .wr_data (MEM_W'(wr_pix)),
    .rd_addr (rd_addr),
    .rd_data (rd_word)
  );

  logic [WEIGHT_W-1:0] rom_w;

  jbrf_exp_rom #(.EXP_ENTRIES(EXP_ENTRIES)) u_rom (
    .clk    (clk),
    .addr   (rom_addr),
    .weight (rom_w)
  );

  // shared multiplier operand select
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [MUL_P_W-1:0] mul_p;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (st == S_WGT) begin
      mul_a = MUL_A_W'(rom_w);
      mul_b = MUL_B_W'(res_mag);
    end else if (st == S_MUL) begin
      case (step)
        OP_FU:   begin mul_a = MUL_A_W'(mag_fu); mul_b = MUL_B_W'(mag_fu); end
        OP_FV:   begin mul_a = MUL_A_W'(mag_fv); mul_b = MUL_B_W'(mag_fv); end
        OP_BU:   begin mul_a = MUL_A_W'(mag_bu); mul_b = MUL_B_W'(mag_bu); end
        OP_BV:   begin mul_a = MUL_A_W'(mag_bv); mul_b = MUL_B_W'(mag_bv); end
        OP_CR:   begin mul_a = MUL_A_W'(mag_r);  mul_b = MUL_B_W'(mag_r);  end
        OP_CG:   begin mul_a = MUL_A_W'(mag_g);  mul_b = MUL_B_W'(mag_g);  end
        OP_CB:   begin mul_a = MUL_A_W'(mag_b);  mul_b = MUL_B_W'(mag_b);  end
        OP_LOC:  begin mul_a = MUL_A_W'(loc);    mul_b = location_scale;   end
        OP_COL:  begin mul_a = csum;             mul_b = colour_scale;     end
        OP_FLO:  begin mul_a = MUL_A_W'(fsum[16:0]);  mul_b = flow_scale;  end
        OP_FHI:  begin mul_a = MUL_A_W'(fsum[33:17]); mul_b = flow_scale;  end
        OP_GLO:  begin mul_a = MUL_A_W'(dist_acc[16:0]);  mul_b = index_gain;  end
        OP_GMID: begin mul_a = MUL_A_W'(dist_acc[33:17]); mul_b = index_gain;  end
        OP_GHI:  begin mul_a = MUL_A_W'(dist_acc[39:34]); mul_b = index_gain;  end
        default: ;
      endcase
    end
  end

  jbrf_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  // divider on magnitudes
  logic             div_start, div_done;
  logic [NUM_W-1:0] num_mag, quo;

  assign div_start = (st == S_DSTART);
  assign num_mag   = num[NUM_W] ? NUM_W'(-num) : NUM_W'(num);

  jbrf_divider #(.NUM_W(NUM_W), .DEN_W(DEN_W)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (num_mag),
    .divisor  (den),
    .done     (div_done),
    .quotient (quo)
  );

  // combinational helpers for each pixel and for the result
  logic [RW-1:0]  dr, dc;
  logic [IW-1:0]  idx_c;
  logic           last_px;
  logic [15:0]    sat_q;

  always_comb begin
    dr = RW'(absdiff_u7(r, {1'b0, row_q}));
    dc = RW'(absdiff_u7(c, {1'b0, col_q}));
    // weight index, saturated at the last ROM entry
    if (index_gain == 24'd0) begin
      idx_c = '0;
    end else if (|dist_acc[59:40]) begin
      idx_c = IW'(EXP_ENTRIES - 1);
    end else if (prod_i[63:24] > 40'(EXP_ENTRIES - 1)) begin
      idx_c = IW'(EXP_ENTRIES - 1);
    end else begin
      idx_c = IW'(prod_i[63:24]);
    end
    last_px = (r == y1) && (c == x1);
    // truncated quotient, signed and clipped to 16 bits
    if (num[NUM_W]) begin
      sat_q = (quo > NUM_W'(32768)) ? 16'h8000 : 16'(~quo + 1'b1);
    end else begin
      sat_q = (quo > NUM_W'(32767)) ? 16'h7fff : 16'(quo);
    end
  end

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= S_IDLE;
      step      <= OP_FU;
      out_valid <= 1'b0;
    end else begin
      // S_DONE drives out_valid itself
      if (out_valid && !out_stall && st != S_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (st)
        S_IDLE: begin
          if (in_acc && func) begin
            row_q <= pixel_row;
            col_q <= pixel_col;
            y0    <= y0_c;
            y1    <= y1_c;
            x0    <= x0_c;
            x1    <= x1_c;
            if (in_frame) begin
              st <= S_CEN;
            end else begin
              res_val <= 16'd0;
              st      <= S_DONE;
            end
          end
        end
        S_CEN: begin
          cen <= rd_pix;
          r   <= y0;
          c   <= x0;
          num <= '0;
          den <= DEN_W'(1);
          st  <= S_RD;
        end
        S_RD: begin
          st <= S_CAP;
        end
        S_CAP: begin
          mag_fu  <= absdiff_s16(rd_pix.fu, cen.fu);
          mag_fv  <= absdiff_s16(rd_pix.fv, cen.fv);
          mag_bu  <= absdiff_s16(rd_pix.bu, cen.bu);
          mag_bv  <= absdiff_s16(rd_pix.bv, cen.bv);
          mag_r   <= absdiff_u8(rd_pix.cr, cen.cr);
          mag_g   <= absdiff_u8(rd_pix.cg, cen.cg);
          mag_b   <= absdiff_u8(rd_pix.cb, cen.cb);
          res_neg <= rd_pix.res[15];
          res_mag <= rd_pix.res[15] ? 16'(-rd_pix.res) : rd_pix.res;
          loc     <= LW'(dr) * LW'(dr) + LW'(dc) * LW'(dc);
          fsum    <= '0;
          csum    <= '0;
          dist_acc <= '0;
          step    <= OP_FU;
          st      <= S_MUL;
        end
        S_MUL: begin
          // a step that takes in a product takes the one issued by the step before
          case (step)
            OP_FV, OP_BU, OP_BV, OP_CR: fsum <= fsum + 34'(mul_p);
            OP_CG, OP_CB, OP_LOC:       csum <= csum + 18'(mul_p);
            OP_COL, OP_FLO, OP_FHI:     dist_acc <= dist_acc + 60'(mul_p);
            OP_DSUM:                    dist_acc <= dist_acc + (60'(mul_p) << 17);
            OP_GMID:                    prod_i <= 64'(mul_p);
            OP_GHI:                     prod_i <= prod_i + (64'(mul_p) << 17);
            OP_GSUM:                    prod_i <= prod_i + (64'(mul_p) << 34);
            default: ;
          endcase
          if (step == OP_IDX) begin
            rom_addr <= idx_c;
            st       <= S_ROM;
          end else begin
            step <= op_t'(step + 1'b1);
          end
        end
        S_ROM: begin
          st <= S_WGT;
        end
        S_WGT: begin
          den <= den + DEN_W'(rom_w);
          st  <= S_ACC;
        end
        S_ACC: begin
          num <= res_neg ? (num - (NUM_W+1)'(mul_p)) : (num + (NUM_W+1)'(mul_p));
          // column outer, row inner
          if (r == y1) begin
            r <= y0;
            c <= c + 7'd1;
          end else begin
            r <= r + 7'd1;
          end
          st <= last_px ? S_DSTART : S_RD;
        end
        S_DSTART: begin
          st <= S_DWAIT;
        end
        S_DWAIT: begin
          if (div_done) begin
            res_val <= sat_q;
            st      <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            out_valid      <= 1'b1;
            out_row        <= row_q;
            out_col        <= col_q;
            filtered_value <= res_val;
            st             <= S_IDLE;
          end
        end
        default: st <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/jbrf_checker.sv
// ----------------------------------------------------------------------------
// Port checker
// Watches the top level's channels; attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none

`include "joint_bilateral_residual_filter_top_defines.svh"

module jbrf_port_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic               func,
  input logic               out_valid,
  input logic               out_stall,
  input logic [5:0]         out_row,
  input logic [5:0]         out_col,
  input logic signed [15:0] filtered_value
);

  // no result straight out of reset
  `JBRF_CHECK_RST(a_reset_quiet, $past(rst) && !rst |-> !out_valid, "result valid after reset")

  // a filter item holds off the next item
  `JBRF_CHECK(a_filter_busy, in_valid && !in_stall && func |=> in_stall, "filter not busy")

  // a write item causes no result
  `JBRF_CHECK(a_write_silent, in_valid && !in_stall && !func && !out_valid |=> !out_valid, "write gave result")

  // a stalled result holds
  `JBRF_CHECK(a_out_hold, out_valid && out_stall |=> out_valid && $stable(filtered_value) && $stable(out_row) && $stable(out_col), "stalled result changed")

endmodule

bind joint_bilateral_residual_filter_top jbrf_port_checker u_jbrf_checker (.*);

`default_nettype wire

FILE: dv/jbrf_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Joint bilateral residual filter: result checker
// Mirrors registers and frame memory from the ports, predicts each filtered
// pixel and compares every result item against the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module jbrf_checker import jbrf_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  input  wire logic                 in_stall,
  input  wire logic                 func,
  input  wire logic [5:0]           pixel_row,
  input  wire logic [5:0]           pixel_col,
  input  wire logic signed [15:0]   residual_value,
  input  wire logic signed [15:0]   forward_u,
  input  wire logic signed [15:0]   forward_v,
  input  wire logic signed [15:0]   backward_u,
  input  wire logic signed [15:0]   backward_v,
  input  wire logic [7:0]           red,
  input  wire logic [7:0]           green,
  input  wire logic [7:0]           blue,
  input  wire logic                 out_valid,
  input  wire logic                 out_stall,
  input  wire logic [5:0]           out_row,
  input  wire logic [5:0]           out_col,
  input  wire logic signed [15:0]   filtered_value,
  input  wire logic                 cfg_write,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  output int                        errors,
  output int                        pending
);

  typedef struct {
    logic [5:0]         row;
    logic [5:0]         col;
    logic signed [15:0] value;
  } pixel_result_t;

  pixel_result_t filtered_q[$];

  // frame memory mirror
  logic signed [15:0] res_mem [4096];
  logic signed [15:0] fu_mem  [4096];
  logic signed [15:0] fv_mem  [4096];
  logic signed [15:0] bu_mem  [4096];
  logic signed [15:0] bv_mem  [4096];
  logic [7:0]         r_mem   [4096];
  logic [7:0]         g_mem   [4096];
  logic [7:0]         b_mem   [4096];

  longint unsigned weight_rom [EXP_ENTRIES_DEF];

  logic [6:0]  rows_reg, cols_reg;
  logic [3:0]  radius_reg;
  logic [23:0] loc_scale, flow_gain, colour_gain, index_gain;

  initial begin : build_rom
    longint unsigned t, acc, term;
    for (int i = 0; i < EXP_ENTRIES_DEF; i++) begin
      t    = ((longint'(i) * 5) << 26) / EXP_ENTRIES_DEF;
      acc  = 64'd1 << 30;
      term = 64'd1 << 30;
      for (int k = 1; k <= 12; k++) begin
        term = ((term * t) >> 30) / k;
        if (k % 2 == 1) acc = acc - term;
        else            acc = acc + term;
      end
      for (int n = 0; n < 4; n++) acc = (acc * acc + (64'd1 << 29)) >> 30;
      weight_rom[i] = (acc + 64'd8192) >> 14;
    end
  end

  function automatic longint unsigned sq_dist(longint a, longint b);
    longint d;
    d = a - b;
    return longint'(d * d);
  endfunction

  function automatic int clamp_dim(logic [6:0] v);
    return (v == 0) ? 1 : ((v > 64) ? 64 : int'(v));
  endfunction

  function automatic logic signed [15:0] predict_filtered(int row, int col);
    int              rows, cols, rad, y0, y1, x0, x1, a, b;
    longint unsigned d, idx, w, den;
    longint          num, q;
    rows = clamp_dim(rows_reg);
    cols = clamp_dim(cols_reg);
    if (row >= rows || col >= cols) return 16'sd0;
    rad = int'(radius_reg);
    a   = row * 64 + col;
    y0  = (row > rad) ? row - rad : 0;
    y1  = (row + rad > rows - 1) ? rows - 1 : row + rad;
    x0  = (col > rad) ? col - rad : 0;
    x1  = (col + rad > cols - 1) ? cols - 1 : col + rad;
    num = 0;
    den = 1;
    for (int c = x0; c <= x1; c++) begin
      for (int r = y0; r <= y1; r++) begin
        b = r * 64 + c;
        d = (sq_dist(r, row) + sq_dist(c, col)) * loc_scale;
        d += (sq_dist(fu_mem[b], fu_mem[a]) + sq_dist(fv_mem[b], fv_mem[a])
              + sq_dist(bu_mem[b], bu_mem[a]) + sq_dist(bv_mem[b], bv_mem[a])) * flow_gain;
        d += (sq_dist(r_mem[b], r_mem[a]) + sq_dist(g_mem[b], g_mem[a])
              + sq_dist(b_mem[b], b_mem[a])) * colour_gain;
        if (index_gain == 0) idx = 0;
        else if ((d >> 40) != 0) idx = EXP_ENTRIES_DEF - 1;
        else begin
          idx = (d * index_gain) >> 24;
          if (idx > EXP_ENTRIES_DEF - 1) idx = EXP_ENTRIES_DEF - 1;
        end
        w   = weight_rom[idx];
        den += w;
        num += longint'(res_mem[b]) * longint'(w);
      end
    end
    q = num / longint'(den);   // truncates toward zero
    if (q > 32767)  q = 32767;
    if (q < -32768) q = -32768;
    return 16'(q);
  endfunction

  always @(posedge clk) begin
    pixel_result_t want;
    int            a;
    if (rst) begin
      rows_reg    <= 7'd64;
      cols_reg    <= 7'd64;
      radius_reg  <= 4'd15;
      loc_scale   <= 24'd65536;
      flow_gain   <= 24'd65536;
      colour_gain <= 24'd65536;
      index_gain  <= 24'd102400;
      filtered_q.delete();
      errors  = 0;
      pending = 0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          CFG_ROWS:   rows_reg    <= cfg_data[6:0];
          CFG_COLS:   cols_reg    <= cfg_data[6:0];
          CFG_RADIUS: radius_reg  <= cfg_data[3:0];
          CFG_LOC:    loc_scale   <= cfg_data;
          CFG_FLOW:   flow_gain   <= cfg_data;
          CFG_COLOUR: colour_gain <= cfg_data;
          CFG_GAIN:   index_gain  <= cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        if (!func) begin
          a = int'(pixel_row) * 64 + int'(pixel_col);
          res_mem[a] = residual_value;
          fu_mem[a]  = forward_u;
          fv_mem[a]  = forward_v;
          bu_mem[a]  = backward_u;
          bv_mem[a]  = backward_v;
          r_mem[a]   = red;
          g_mem[a]   = green;
          b_mem[a]   = blue;
        end else begin
          want.row   = pixel_row;
          want.col   = pixel_col;
          want.value = predict_filtered(int'(pixel_row), int'(pixel_col));
          filtered_q.push_back(want);
        end
      end
      if (out_valid && !out_stall) begin
        if (filtered_q.size() == 0) begin
          if (errors < 10)
            $display("mismatch: unexpected item row %0d col %0d value %0d",
                     out_row, out_col, filtered_value);
          errors++;
        end else begin
          want = filtered_q.pop_front();
          if (want.row !== out_row || want.col !== out_col || want.value !== filtered_value)
          begin
            if (errors < 10)
              $display("mismatch: exp row %0d col %0d value %0d, got row %0d col %0d value %0d",
                       want.row, want.col, want.value, out_row, out_col, filtered_value);
            errors++;
          end
        end
      end
      pending = filtered_q.size();
    end
  end

endmodule

`default_nettype wire

FILE: dv/joint_bilateral_residual_filter_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Joint bilateral residual filter testbench
// Loads pixels, filters them under directed and random register settings,
// with random idling on both channels; the checker scores every result.
// ----------------------------------------------------------------------------
`default_nettype none

module joint_bilateral_residual_filter_top_tb import jbrf_pkg::*;;

  localparam int LIMIT = 3000000;   // cycles, far above the slowest legal run

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic                 func = 1'b0;
  logic [5:0]           pixel_row = '0;
  logic [5:0]           pixel_col = '0;
  logic signed [15:0]   residual_value = '0;
  logic signed [15:0]   forward_u = '0;
  logic signed [15:0]   forward_v = '0;
  logic signed [15:0]   backward_u = '0;
  logic signed [15:0]   backward_v = '0;
  logic [7:0]           red = '0;
  logic [7:0]           green = '0;
  logic [7:0]           blue = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [5:0]           out_row;
  logic [5:0]           out_col;
  logic signed [15:0]   filtered_value;
  logic                 cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_ROWS;
  logic [CFG_W-1:0]     cfg_data = '0;

  int errors, pending;
  int cycles = 0;
  bit calm = 1'b0;          // no idling on either side while set
  bit written [4096];       // pixels loaded so far; never read unloaded ones
  int frame_rows = 64, frame_cols = 64, radius = 15;

  always #5 clk = ~clk;

  joint_bilateral_residual_filter_top dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .func(func),
    .pixel_row(pixel_row), .pixel_col(pixel_col), .residual_value(residual_value),
    .forward_u(forward_u), .forward_v(forward_v),
    .backward_u(backward_u), .backward_v(backward_v),
    .red(red), .green(green), .blue(blue),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_row(out_row), .out_col(out_col), .filtered_value(filtered_value),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  jbrf_checker u_scoreboard (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .func(func),
    .pixel_row(pixel_row), .pixel_col(pixel_col), .residual_value(residual_value),
    .forward_u(forward_u), .forward_v(forward_v),
    .backward_u(backward_u), .backward_v(backward_v),
    .red(red), .green(green), .blue(blue),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_row(out_row), .out_col(out_col), .filtered_value(filtered_value),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .errors(errors), .pending(pending)
  );

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // result side backpressure, changed on the falling edge
  initial begin
    forever begin
      @(negedge clk);
      out_stall = !calm && ($urandom_range(99) < 21);
    end
  end

  // mostly small flows so weights stay alive, with extremes mixed in
  function automatic logic signed [15:0] pick_flow();
    case ($urandom_range(9))
      0:       return 16'sh8000;
      1:       return 16'sh7fff;
      2, 3:    return 16'($urandom);
      default: return 16'($signed($urandom_range(128)) - 64);
    endcase
  endfunction

  function automatic logic [7:0] pick_colour();
    case ($urandom_range(9))
      0:       return 8'd0;
      1:       return 8'd255;
      2, 3:    return 8'($urandom);
      default: return 8'(100 + $urandom_range(40));
    endcase
  endfunction

  function automatic logic signed [15:0] pick_residual();
    case ($urandom_range(7))
      0:       return 16'sh8000;
      1:       return 16'sh7fff;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic int clamp_dim(int v);
    return (v == 0) ? 1 : ((v > 64) ? 64 : v);
  endfunction

  task automatic send_item(bit f, int r, int c, logic signed [15:0] res,
                           logic signed [15:0] fu, logic signed [15:0] fv,
                           logic signed [15:0] bu, logic signed [15:0] bv,
                           logic [7:0] cr, logic [7:0] cg, logic [7:0] cb);
    if (!calm) begin
      while ($urandom_range(99) < 21) begin
        in_valid = 1'b0;
        @(negedge clk);
      end
    end
    func = f;
    pixel_row = 6'(r);
    pixel_col = 6'(c);
    residual_value = res;
    forward_u = fu;
    forward_v = fv;
    backward_u = bu;
    backward_v = bv;
    red = cr;
    green = cg;
    blue = cb;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    if (!f) written[r * 64 + c] = 1'b1;
  endtask

  task automatic load_pixel(int r, int c);
    send_item(1'b0, r, c, pick_residual(), pick_flow(), pick_flow(), pick_flow(),
              pick_flow(), pick_colour(), pick_colour(), pick_colour());
  endtask

  // filter item; any unloaded pixel of its window gets loaded first
  task automatic filter_pixel(int r, int c);
    if (r < frame_rows && c < frame_cols) begin
      for (int rr = (r > radius ? r - radius : 0);
           rr <= (r + radius > frame_rows - 1 ? frame_rows - 1 : r + radius); rr++)
        for (int cc = (c > radius ? c - radius : 0);
             cc <= (c + radius > frame_cols - 1 ? frame_cols - 1 : c + radius); cc++)
          if (!written[rr * 64 + cc]) load_pixel(rr, cc);
    end
    // other fields are don't-care for a filter item; keep them moving
    send_item(1'b1, r, c, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
              16'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  // block is idle once all results are in and a write has had time to land
  task automatic drain();
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned value);
    drain();
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data  = CFG_W'(value);
    @(negedge clk);
    cfg_write = 1'b0;
    case (idx)
      CFG_ROWS:   frame_rows = clamp_dim(value & 32'h7f);
      CFG_COLS:   frame_cols = clamp_dim(value & 32'h7f);
      CFG_RADIUS: radius = value & 32'hf;
      default: ;
    endcase
  endtask

  initial begin
    int r, c;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // ---- directed: reset settings, full radius in the corner
    send_item(1'b0, 0, 0, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
              8'd255, 8'd255, 8'd255);
    send_item(1'b0, 0, 1, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff,
              8'd0, 8'd0, 8'd0);
    send_item(1'b0, 63, 63, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff,
              8'd255, 8'd255, 8'd255);
    filter_pixel(0, 0);
    filter_pixel(0, 1);

    // ---- directed: register extremes, zero scales, zero gain, bogus index
    write_reg(3'd7, 24'hffffff);            // beyond the register list: ignored
    write_reg(CFG_ROWS, 0);                 // clamps up to one row
    write_reg(CFG_COLS, 127);               // clamps down to the memory width
    write_reg(CFG_RADIUS, 0);
    write_reg(CFG_LOC, 0);
    write_reg(CFG_FLOW, 0);
    write_reg(CFG_COLOUR, 0);
    write_reg(CFG_GAIN, 0);                 // every weight from entry zero
    filter_pixel(0, 5);
    filter_pixel(0, 63);
    filter_pixel(1, 0);                     // outside the frame
    filter_pixel(63, 63);

    // ---- directed: saturating distance and ROM index
    write_reg(CFG_ROWS, 64);
    write_reg(CFG_RADIUS, 2);
    write_reg(CFG_LOC, 24'hffffff);
    write_reg(CFG_FLOW, 24'hffffff);
    write_reg(CFG_COLOUR, 24'hffffff);
    write_reg(CFG_GAIN, 24'hffffff);
    filter_pixel(0, 0);
    filter_pixel(1, 1);
    write_reg(CFG_RADIUS, 15);
    write_reg(CFG_GAIN, 1);
    filter_pixel(0, 1);

    // ---- random phases
    for (int ph = 0; ph < 8; ph++) begin
      calm = (ph == 3);
      write_reg(CFG_RADIUS, ($urandom_range(3) == 0) ? $urandom_range(15) : $urandom_range(3));
      if (radius > 1) begin
        // wider windows only on small frames to bound the item count
        write_reg(CFG_ROWS, $urandom_range(1, 10));
        write_reg(CFG_COLS, $urandom_range(1, 10));
      end else begin
        write_reg(CFG_ROWS, ($urandom_range(3) == 0) ? $urandom_range(127) : $urandom_range(1, 20));
        write_reg(CFG_COLS, ($urandom_range(3) == 0) ? $urandom_range(127) : $urandom_range(1, 20));
      end
      write_reg(CFG_LOC, ($urandom_range(4) == 0) ? $urandom : $urandom_range(1 << 18));
      write_reg(CFG_FLOW, ($urandom_range(4) == 0) ? $urandom : $urandom_range(1 << 14));
      write_reg(CFG_COLOUR, ($urandom_range(4) == 0) ? $urandom : $urandom_range(1 << 14));
      write_reg(CFG_GAIN, ($urandom_range(4) == 0) ? $urandom : $urandom_range(1 << 20));
      for (int n = 0; n < 24; n++) begin
        if (ph == 5 && n == 12) drain();    // let the pipeline run dry once
        if ($urandom_range(3) == 0) begin
          r = $urandom_range(63);
          c = $urandom_range(63);
        end else begin
          r = $urandom_range(frame_rows - 1);
          c = $urandom_range(frame_cols - 1);
        end
        if ($urandom_range(1) == 0) load_pixel(r, c);
        else filter_pixel(r, c);
      end
    end
    calm = 1'b0;

    drain();
    repeat (50) @(negedge clk);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: sim.f
+incdir+rtl/core
rtl/core/jbrf_pkg.sv
rtl/core/jbrf_frame_mem.sv
rtl/core/jbrf_exp_rom.sv
rtl/core/jbrf_mul.sv
rtl/core/jbrf_divider.sv
rtl/core/joint_bilateral_residual_filter_top.sv
rtl/core/jbrf_checker.sv
dv/jbrf_checker.sv
dv/joint_bilateral_residual_filter_top_tb.sv
